// ----- hdl/bresenham_line_rasterizer_core_macros.svh -----
// Assertion macros shared by the line rasterizer RTL.
`ifndef BRESENHAM_LINE_RASTERIZER_CORE_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define BLR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define BLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/blr_pkg.sv -----
// Shared constants and control types of the line rasterizer.
package blr_pkg;

    localparam int COORD_BITS_DEFAULT = 6;

    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 7;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_IDX_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_BITS-1:0] CANVAS_WIDTH_RESET  = 7'd60;
    localparam logic [CFG_DATA_BITS-1:0] CANVAS_HEIGHT_RESET = 7'd20;

    // controller -> datapath
    typedef struct packed {
        logic load;     // take a new segment into the walk registers
        logic step;     // emit current pixel and advance the walk
    } blr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic at_end;   // current pixel equals the end point
        logic out_free; // output register can take a pixel this cycle
    } blr_stat_t;

endpackage

// ----- hdl/blr_seg_if.sv -----
// Segment input channel: two endpoints per item.
interface blr_seg_if #(
    parameter int COORD_BITS = blr_pkg::COORD_BITS_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// ----- hdl/blr_pix_if.sv -----
// Pixel output channel: one pixel per item.
interface blr_pix_if #(
    parameter int COORD_BITS = blr_pkg::COORD_BITS_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  on_canvas;
    logic                  last_pixel;

    modport source (output valid, pixel_x, pixel_y, on_canvas, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, on_canvas, last_pixel, output ready);
endinterface

// ----- hdl/blr_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface blr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [blr_pkg::CFG_ADDR_BITS-1:0]  index;
    logic [blr_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/bresenham_line_rasterizer_core.sv -----
// Top level of the Bresenham line rasterizer.
//
// Usage:
//   cfg : register writes, always ready. Index 0 = canvas width, index 1 =
//         canvas height (7 bits each); other indexes are dropped. Write only
//         while no segment is in flight.
//   seg : one item = one segment (start_x, start_y, end_x, end_y).
//   pix : one item per pixel of the all-octant walk, start to end inclusive,
//         with on_canvas (x < width and y < height) and last_pixel on the end.
// Path: the segment loads the walk registers, then each pixel passes through
//   the output register to pix. Throughput: one pixel per cycle while pix
//   takes them; a segment of N = max(|dx|,|dy|)+1 pixels (at most
//   2^COORD_BITS) is walked by the single walk register set, one step a cycle.
// seg is ready again the cycle after the last pixel enters the output
//   register, even if that pixel is still waiting on pix.
// Stall: when pix holds ready low, the output register keeps its pixel and
//   the walk pauses; nothing is dropped or repeated.
// Reset: asynchronous, active low; returns to idle, drops any pending pixel
//   and restores canvas width 60 and height 20.
module bresenham_line_rasterizer_core #(
    parameter int COORD_BITS = blr_pkg::COORD_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    blr_cfg_if.sink      cfg,
    blr_seg_if.sink      seg,
    blr_pix_if.source    pix
);

    blr_pkg::blr_cmd_t  cmd;
    blr_pkg::blr_stat_t stat;

    // config registers accept at any time
    assign cfg.ready = 1'b1;

    // state machine: owns the segment handshake and sequences the walk
    blr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg.valid),
        .seg_ready (seg.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: walk registers, error term, canvas test, pixel output register
    blr_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .start_x       (seg.start_x),
        .start_y       (seg.start_y),
        .end_x         (seg.end_x),
        .end_y         (seg.end_y),
        .pix_valid     (pix.valid),
        .pix_ready     (pix.ready),
        .pix_x         (pix.pixel_x),
        .pix_y         (pix.pixel_y),
        .pix_on_canvas (pix.on_canvas),
        .pix_last      (pix.last_pixel)
    );

endmodule

// ----- hdl/blr_ctrl.sv -----
// Segment walk controller: idle/walk state machine.
`include "bresenham_line_rasterizer_core_macros.svh"

module blr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               seg_valid,
    output logic               seg_ready,
    input  blr_pkg::blr_stat_t stat,
    output blr_pkg::blr_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } blr_state_t;

    blr_state_t state_reg;
    blr_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        seg_ready  = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (seg_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.out_free)
                begin
                    cmd.step = 1'b1;
                    if (stat.at_end)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `BLR_ASSERT_NEXT(a_load_starts_walk, cmd.load, state_reg == ST_WALK && !seg_ready, "load did not start a walk")
    `BLR_ASSERT_NEXT(a_end_frees_input, cmd.step && stat.at_end, seg_ready, "input not free after last pixel")

endmodule

// ----- hdl/blr_datapath.sv -----
// Walk registers, error update, canvas test, config and pixel output register.
`include "bresenham_line_rasterizer_core_macros.svh"

module blr_datapath #(
    parameter int COORD_BITS = blr_pkg::COORD_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  blr_pkg::blr_cmd_t                 cmd,
    output blr_pkg::blr_stat_t                stat,
    input  logic                              cfg_valid,
    input  logic [blr_pkg::CFG_ADDR_BITS-1:0] cfg_index,
    input  logic [blr_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic [COORD_BITS-1:0]             start_x,
    input  logic [COORD_BITS-1:0]             start_y,
    input  logic [COORD_BITS-1:0]             end_x,
    input  logic [COORD_BITS-1:0]             end_y,
    output logic                              pix_valid,
    input  logic                              pix_ready,
    output logic [COORD_BITS-1:0]             pix_x,
    output logic [COORD_BITS-1:0]             pix_y,
    output logic                              pix_on_canvas,
    output logic                              pix_last
);

    // error term headroom: doubled error stays below 2^(COORD_BITS+2)
    localparam int EXT = 3;
    localparam int EW  = COORD_BITS + EXT;
    localparam int CMP_W = (COORD_BITS > blr_pkg::CFG_DATA_BITS) ?
                           COORD_BITS : blr_pkg::CFG_DATA_BITS;

    logic [blr_pkg::CFG_DATA_BITS-1:0] canvas_w_reg, canvas_w_next;
    logic [blr_pkg::CFG_DATA_BITS-1:0] canvas_h_reg, canvas_h_next;

    logic [COORD_BITS-1:0] walk_x_reg, walk_x_next;
    logic [COORD_BITS-1:0] walk_y_reg, walk_y_next;
    logic [COORD_BITS-1:0] target_x_reg, target_x_next;
    logic [COORD_BITS-1:0] target_y_reg, target_y_next;
    logic [COORD_BITS-1:0] abs_dx_reg, abs_dx_next;
    logic [COORD_BITS-1:0] abs_dy_reg, abs_dy_next;
    logic                  x_neg_reg, x_neg_next;
    logic                  y_neg_reg, y_neg_next;
    logic signed [EW-1:0]  err_reg, err_next;

    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] out_x_reg, out_x_next;
    logic [COORD_BITS-1:0] out_y_reg, out_y_next;
    logic                  out_canvas_reg, out_canvas_next;
    logic                  out_last_reg, out_last_next;

    logic                  ld_x_neg, ld_y_neg;
    logic [COORD_BITS-1:0] ld_abs_dx, ld_abs_dy;
    logic signed [EW-1:0]  adx_s, nady_s, doubled;
    logic                  move_x, move_y;
    logic                  at_end, on_canvas;

    // setup for a new segment
    always_comb
    begin
        ld_x_neg  = !(start_x < end_x);
        ld_y_neg  = !(start_y < end_y);
        ld_abs_dx = ld_x_neg ? (start_x - end_x) : (end_x - start_x);
        ld_abs_dy = ld_y_neg ? (start_y - end_y) : (end_y - start_y);
    end

    // one Bresenham step
    always_comb
    begin
        adx_s   = $signed({{EXT{1'b0}}, abs_dx_reg});
        nady_s  = -$signed({{EXT{1'b0}}, abs_dy_reg});
        doubled = err_reg <<< 1;
        move_x  = (doubled >= nady_s);
        move_y  = (doubled <= adx_s);
        at_end  = (walk_x_reg == target_x_reg) && (walk_y_reg == target_y_reg);
        on_canvas = (CMP_W'(walk_x_reg) < CMP_W'(canvas_w_reg)) &&
                    (CMP_W'(walk_y_reg) < CMP_W'(canvas_h_reg));
    end

    assign stat.at_end   = at_end;
    assign stat.out_free = !out_valid_reg || pix_ready;

    always_comb
    begin
        walk_x_next   = walk_x_reg;
        walk_y_next   = walk_y_reg;
        target_x_next = target_x_reg;
        target_y_next = target_y_reg;
        abs_dx_next   = abs_dx_reg;
        abs_dy_next   = abs_dy_reg;
        x_neg_next    = x_neg_reg;
        y_neg_next    = y_neg_reg;
        err_next      = err_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_canvas_next = out_canvas_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !pix_ready;

        if (cmd.load)
        begin
            walk_x_next   = start_x;
            walk_y_next   = start_y;
            target_x_next = end_x;
            target_y_next = end_y;
            abs_dx_next   = ld_abs_dx;
            abs_dy_next   = ld_abs_dy;
            x_neg_next    = ld_x_neg;
            y_neg_next    = ld_y_neg;
            err_next      = $signed({{EXT{1'b0}}, ld_abs_dx}) -
                            $signed({{EXT{1'b0}}, ld_abs_dy});
        end
        else if (cmd.step)
        begin
            out_valid_next  = 1'b1;
            out_x_next      = walk_x_reg;
            out_y_next      = walk_y_reg;
            out_canvas_next = on_canvas;
            out_last_next   = at_end;
            if (move_x)
            begin
                walk_x_next = x_neg_reg ? (walk_x_reg - 1'b1) : (walk_x_reg + 1'b1);
            end
            if (move_y)
            begin
                walk_y_next = y_neg_reg ? (walk_y_reg - 1'b1) : (walk_y_reg + 1'b1);
            end
            err_next = err_reg + (move_x ? nady_s : '0) + (move_y ? adx_s : '0);
        end
    end

    // configuration registers, writes beyond the list are dropped
    always_comb
    begin
        canvas_w_next = canvas_w_reg;
        canvas_h_next = canvas_h_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                blr_pkg::CFG_IDX_WIDTH:  canvas_w_next = cfg_data;
                blr_pkg::CFG_IDX_HEIGHT: canvas_h_next = cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_w_reg  <= blr_pkg::CANVAS_WIDTH_RESET;
            canvas_h_reg  <= blr_pkg::CANVAS_HEIGHT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            canvas_w_reg  <= canvas_w_next;
            canvas_h_reg  <= canvas_h_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_x_reg     <= walk_x_next;
        walk_y_reg     <= walk_y_next;
        target_x_reg   <= target_x_next;
        target_y_reg   <= target_y_next;
        abs_dx_reg     <= abs_dx_next;
        abs_dy_reg     <= abs_dy_next;
        x_neg_reg      <= x_neg_next;
        y_neg_reg      <= y_neg_next;
        err_reg        <= err_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_canvas_reg <= out_canvas_next;
        out_last_reg   <= out_last_next;
    end

    assign pix_valid     = out_valid_reg;
    assign pix_x         = out_x_reg;
    assign pix_y         = out_y_reg;
    assign pix_on_canvas = out_canvas_reg;
    assign pix_last      = out_last_reg;

    `BLR_ASSERT_IMPL(a_step_no_overwrite, cmd.step, !out_valid_reg || pix_ready, "pixel overwritten while stalled")
    `BLR_ASSERT_NEXT(a_step_moves, cmd.step && !at_end, walk_x_reg != $past(walk_x_reg) || walk_y_reg != $past(walk_y_reg), "walk did not advance")

endmodule
